### rtl/core/lpfr_pkg.sv
// Package for the length-prefixed frame receiver.
// Holds byte role, status and phase codes and the shared types; no dependencies.
package lpfr_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ROLE_W   = 3;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned MAXLEN_W = 17;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned INDEX_W  = 2;
    localparam int unsigned TDATA_W  = 48;
    localparam int unsigned OVERHEAD = 5;

    localparam logic [ROLE_W-1:0] ROLE_DISCARD = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_START   = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_LEN_LO  = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_LEN_HI  = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_CHECK   = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_FOOTER  = 3'd6;

    localparam logic [STATUS_W-1:0] STAT_PENDING    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_GOOD       = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_CHECK  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_FOOTER = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_TOO_LONG   = 3'd4;

    localparam logic [PHASE_W-1:0] PH_HUNT   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LEN_LO = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI = 2'd2;
    localparam logic [PHASE_W-1:0] PH_BODY   = 2'd3;

    localparam logic [INDEX_W-1:0] REG_START_BYTE  = 2'd0;
    localparam logic [INDEX_W-1:0] REG_FOOTER_BYTE = 2'd1;
    localparam logic [INDEX_W-1:0] REG_MAX_LEN     = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]   start_byte;
        logic [BYTE_W-1:0]   footer_byte;
        logic [MAXLEN_W-1:0] max_frame_len;
    } t_cfg;

    typedef struct packed {
        logic [ROLE_W-1:0]   byte_role;
        logic [BYTE_W-1:0]   data_byte;
        logic [FIELD_W-1:0]  payload_index;
        logic [FIELD_W-1:0]  payload_length;
        logic                frame_end;
        logic [STATUS_W-1:0] frame_status;
    } t_result;

endpackage

### rtl/core/length_prefixed_frame_receiver.sv
// Length-prefixed frame receiver top level.
// Holds the configuration registers; instantiates lpfr_parser and lpfr_out_reg.
//
// Usage:
//   Slave stream s_axis_* carries one received byte per transaction.
//   Master stream m_axis_* returns one result per input byte, in order:
//   tdata holds the byte and its frame information, tuser its role in the
//   frame, tlast marks the byte that ends or aborts a frame.
//   Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_wdata
//   (0 start byte, 1 footer byte, 2 maximum total frame length) while idle.
// Timing:
//   The result is valid in the cycle after the input transaction. One byte
//   per cycle is sustained while m_axis_tready stays high; the frame state and
//   the result register both update in the cycle of the input transaction.
// Reset:
//   Synchronous, active low. Clears the frame state to hunting, empties the
//   result register and loads start 0, footer 0 and maximum length 256.
// Stall:
//   While a result waits with m_axis_tready low, s_axis_tready drops and
//   the result is held; a new byte is taken in the cycle the result leaves.
module length_prefixed_frame_receiver #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lpfr_pkg::INDEX_W-1:0]      i_cfg_index,
    input  logic [lpfr_pkg::MAXLEN_W-1:0]     i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // rx_byte[7:0]
    input  logic [lpfr_pkg::BYTE_W-1:0]       s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // data_byte[7:0], payload_index[23:8], payload_length[39:24],
    // frame_status[42:40], zero[47:43]
    output logic [lpfr_pkg::TDATA_W-1:0]      m_axis_tdata,
    // byte_role[2:0]
    output logic [lpfr_pkg::ROLE_W-1:0]       m_axis_tuser,
    output logic                              m_axis_tlast
);

    lpfr_pkg::t_cfg    r_cfg;
    lpfr_pkg::t_result w_result;
    lpfr_pkg::t_result w_out;
    logic              w_accept;
    logic              w_can_load;

    assign s_axis_tready = w_can_load;
    assign w_accept      = s_axis_tvalid && w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte    <= '0;
            r_cfg.footer_byte   <= '0;
            r_cfg.max_frame_len <= lpfr_pkg::MAXLEN_W'(256);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lpfr_pkg::REG_START_BYTE:  r_cfg.start_byte    <= i_cfg_wdata[lpfr_pkg::BYTE_W-1:0];
                lpfr_pkg::REG_FOOTER_BYTE: r_cfg.footer_byte   <= i_cfg_wdata[lpfr_pkg::BYTE_W-1:0];
                lpfr_pkg::REG_MAX_LEN:     r_cfg.max_frame_len <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    lpfr_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_advance (w_accept),
        .i_rx_byte (s_axis_tdata),
        .o_result  (w_result)
    );

    lpfr_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_result   (w_result),
        .i_ready    (m_axis_tready),
        .o_valid    (m_axis_tvalid),
        .o_can_load (w_can_load),
        .o_result   (w_out)
    );

    assign m_axis_tdata = {5'b0, w_out.frame_status, w_out.payload_length,
                           w_out.payload_index, w_out.data_byte};
    assign m_axis_tuser = w_out.byte_role;
    assign m_axis_tlast = w_out.frame_end;

endmodule

### rtl/core/lpfr_parser.sv
// Frame parser: phase tracking, length check, payload count and running XOR.
// Produces one result per accepted byte combinationally; uses lpfr_pkg.
module lpfr_parser #(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lpfr_pkg::t_cfg                i_cfg,
    input  logic                          i_advance,
    input  logic [lpfr_pkg::BYTE_W-1:0]   i_rx_byte,
    output lpfr_pkg::t_result             o_result
);

    logic [lpfr_pkg::PHASE_W-1:0] r_phase,    n_phase;
    logic [lpfr_pkg::BYTE_W-1:0]  r_len_low,  n_len_low;
    logic [LENGTH_BITS-1:0]       r_plen,     n_plen;
    logic [LENGTH_BITS:0]         r_idx,      n_idx;
    logic [lpfr_pkg::BYTE_W-1:0]  r_xor,      n_xor;
    logic [lpfr_pkg::BYTE_W-1:0]  r_check,    n_check;

    logic [LENGTH_BITS-1:0]         w_len;
    logic [lpfr_pkg::MAXLEN_W-1:0]  w_total;

    assign w_len   = LENGTH_BITS'({i_rx_byte, r_len_low});
    assign w_total = lpfr_pkg::MAXLEN_W'(w_len) + lpfr_pkg::MAXLEN_W'(lpfr_pkg::OVERHEAD);

    always_comb begin
        n_phase   = r_phase;
        n_len_low = r_len_low;
        n_plen    = r_plen;
        n_idx     = r_idx;
        n_xor     = r_xor;
        n_check   = r_check;

        o_result                = '0;
        o_result.byte_role      = lpfr_pkg::ROLE_DISCARD;
        o_result.data_byte      = i_rx_byte;
        o_result.frame_status   = lpfr_pkg::STAT_PENDING;

        case (r_phase)
            lpfr_pkg::PH_HUNT: begin
                if (i_rx_byte == i_cfg.start_byte) begin
                    o_result.byte_role = lpfr_pkg::ROLE_START;
                    n_phase            = lpfr_pkg::PH_LEN_LO;
                end
            end
            lpfr_pkg::PH_LEN_LO: begin
                o_result.byte_role = lpfr_pkg::ROLE_LEN_LO;
                n_len_low          = i_rx_byte;
                n_phase            = lpfr_pkg::PH_LEN_HI;
            end
            lpfr_pkg::PH_LEN_HI: begin
                o_result.byte_role      = lpfr_pkg::ROLE_LEN_HI;
                o_result.payload_length = lpfr_pkg::FIELD_W'(w_len);
                if (w_total > i_cfg.max_frame_len) begin
                    o_result.frame_end    = 1'b1;
                    o_result.frame_status = lpfr_pkg::STAT_TOO_LONG;
                    n_phase               = lpfr_pkg::PH_HUNT;
                end else begin
                    n_phase = lpfr_pkg::PH_BODY;
                    n_plen  = w_len;
                    n_idx   = '0;
                    n_xor   = '0;
                end
            end
            lpfr_pkg::PH_BODY: begin
                o_result.payload_length = lpfr_pkg::FIELD_W'(r_plen);
                if (r_idx < {1'b0, r_plen}) begin
                    o_result.byte_role     = lpfr_pkg::ROLE_PAYLOAD;
                    o_result.payload_index = lpfr_pkg::FIELD_W'(r_idx[LENGTH_BITS-1:0]);
                    n_xor                  = r_xor ^ i_rx_byte;
                    n_idx                  = r_idx + 1'b1;
                end else if (r_idx == {1'b0, r_plen}) begin
                    o_result.byte_role = lpfr_pkg::ROLE_CHECK;
                    n_check            = i_rx_byte;
                    n_idx              = r_idx + 1'b1;
                end else begin
                    o_result.byte_role = lpfr_pkg::ROLE_FOOTER;
                    o_result.frame_end = 1'b1;
                    if (i_rx_byte != i_cfg.footer_byte) begin
                        o_result.frame_status = lpfr_pkg::STAT_BAD_FOOTER;
                    end else if (r_xor != r_check) begin
                        o_result.frame_status = lpfr_pkg::STAT_BAD_CHECK;
                    end else begin
                        o_result.frame_status = lpfr_pkg::STAT_GOOD;
                    end
                    n_phase = lpfr_pkg::PH_HUNT;
                end
            end
            default: begin
                n_phase = lpfr_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lpfr_pkg::PH_HUNT;
        end else if (i_advance) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_len_low <= n_len_low;
            r_plen    <= n_plen;
            r_idx     <= n_idx;
            r_xor     <= n_xor;
            r_check   <= n_check;
        end
    end

endmodule

### rtl/core/lpfr_out_reg.sv
// Result register with valid flag for the master-side stream.
// Loads on each input transaction, holds while the receiver stalls; uses lpfr_pkg.
module lpfr_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  lpfr_pkg::t_result  i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_can_load,
    output lpfr_pkg::t_result  o_result
);

    logic              r_valid;
    lpfr_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

### rtl/core/lpfr_checker.sv
// Port-level checker for the length-prefixed frame receiver, with its bind.
// Depends on lpfr_pkg and the top-level port list.
module lpfr_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [lpfr_pkg::TDATA_W-1:0]      m_axis_tdata,
    input logic [lpfr_pkg::ROLE_W-1:0]       m_axis_tuser,
    input logic                              m_axis_tlast
);

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_status_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[42:40] != lpfr_pkg::STAT_PENDING)))
        else $error("frame status and end flag disagree");

    a_index_payload_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != lpfr_pkg::ROLE_PAYLOAD)
            |-> (m_axis_tdata[23:8] == '0))
        else $error("payload index outside payload");

    a_end_roles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            (m_axis_tuser == lpfr_pkg::ROLE_LEN_HI) || (m_axis_tuser == lpfr_pkg::ROLE_FOOTER))
        else $error("frame end on wrong byte role");

    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind length_prefixed_frame_receiver lpfr_checker u_lpfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### bench/lpfr_frame_checker.sv
// Scoreboard for the length-prefixed frame receiver: tracks register writes,
// predicts one result per accepted byte and compares the output stream.
// Depends on lpfr_pkg for widths, role, status, phase and register codes.
module lpfr_frame_checker
    import lpfr_pkg::*;
#(
    parameter int unsigned LENGTH_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [INDEX_W-1:0]   i_cfg_index,
    input  logic [MAXLEN_W-1:0]  i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [TDATA_W-1:0]   m_axis_tdata,
    input  logic [ROLE_W-1:0]    m_axis_tuser,
    input  logic                 m_axis_tlast,
    output int                   o_fail_count,
    output int                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [BYTE_W-1:0]   cfg_start;
    logic [BYTE_W-1:0]   cfg_footer;
    logic [MAXLEN_W-1:0] cfg_max_len;

    logic [PHASE_W-1:0]  rx_phase;
    logic [MAXLEN_W-1:0] taken_count;
    logic [MAXLEN_W-1:0] frame_len_total;
    logic [BYTE_W-1:0]   len_low_byte;
    logic [BYTE_W-1:0]   payload_xor;
    logic [BYTE_W-1:0]   check_byte;

    t_result expected_results[$];
    int      fail_count  = 0;
    int      outstanding = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding;

    function automatic void drop_frame();
        rx_phase        = PH_HUNT;
        taken_count     = '0;
        frame_len_total = '0;
        len_low_byte    = '0;
        payload_xor     = '0;
        check_byte      = '0;
    endfunction

    function automatic t_result deframe_byte(input logic [BYTE_W-1:0] b);
        t_result             r;
        logic [FIELD_W-1:0]  len_mask;
        logic [FIELD_W-1:0]  plen;
        r           = '0;
        r.data_byte = b;
        len_mask    = FIELD_W'((32'd1 << LENGTH_BITS) - 32'd1);
        case (rx_phase)
            PH_HUNT: begin
                if (b == cfg_start) begin
                    r.byte_role = ROLE_START;
                    rx_phase    = PH_LEN_LO;
                    taken_count = MAXLEN_W'(1);
                end
            end
            PH_LEN_LO: begin
                r.byte_role  = ROLE_LEN_LO;
                len_low_byte = b;
                rx_phase     = PH_LEN_HI;
                taken_count  = MAXLEN_W'(2);
            end
            PH_LEN_HI: begin
                r.byte_role      = ROLE_LEN_HI;
                plen             = {b, len_low_byte} & len_mask;
                r.payload_length = plen;
                frame_len_total  = MAXLEN_W'(plen) + MAXLEN_W'(OVERHEAD);
                if (frame_len_total > cfg_max_len) begin
                    r.frame_end    = 1'b1;
                    r.frame_status = STAT_TOO_LONG;
                    drop_frame();
                end else begin
                    rx_phase    = PH_BODY;
                    taken_count = MAXLEN_W'(3);
                end
            end
            default: begin
                r.payload_length = FIELD_W'(frame_len_total - MAXLEN_W'(OVERHEAD));
                if (32'(taken_count) + 32'd2 < 32'(frame_len_total)) begin
                    r.byte_role     = ROLE_PAYLOAD;
                    r.payload_index = FIELD_W'(taken_count - MAXLEN_W'(3));
                    payload_xor     = payload_xor ^ b;
                    taken_count     = taken_count + MAXLEN_W'(1);
                end else if (32'(taken_count) + 32'd2 == 32'(frame_len_total)) begin
                    r.byte_role = ROLE_CHECK;
                    check_byte  = b;
                    taken_count = taken_count + MAXLEN_W'(1);
                end else begin
                    r.byte_role = ROLE_FOOTER;
                    r.frame_end = 1'b1;
                    if (b != cfg_footer) r.frame_status = STAT_BAD_FOOTER;
                    else if (payload_xor != check_byte) r.frame_status = STAT_BAD_CHECK;
                    else r.frame_status = STAT_GOOD;
                    drop_frame();
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            cfg_start   = '0;
            cfg_footer  = '0;
            cfg_max_len = MAXLEN_W'(256);
            drop_frame();
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_START_BYTE:  cfg_start   = i_cfg_wdata[BYTE_W-1:0];
                    REG_FOOTER_BYTE: cfg_footer  = i_cfg_wdata[BYTE_W-1:0];
                    REG_MAX_LEN:     cfg_max_len = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no byte outstanding: data_byte %0h",
                           m_axis_tdata[7:0]);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("byte_role", 32'(want.byte_role), 32'(m_axis_tuser));
                    check_field("data_byte", 32'(want.data_byte), 32'(m_axis_tdata[7:0]));
                    check_field("payload_index", 32'(want.payload_index),
                                32'(m_axis_tdata[23:8]));
                    check_field("payload_length", 32'(want.payload_length),
                                32'(m_axis_tdata[39:24]));
                    check_field("frame_end", 32'(want.frame_end), 32'(m_axis_tlast));
                    check_field("frame_status", 32'(want.frame_status),
                                32'(m_axis_tdata[42:40]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(deframe_byte(s_axis_tdata));
        end
        outstanding = expected_results.size();
    end

endmodule

### bench/length_prefixed_frame_receiver_tb.sv
// Stimulus and verdict for the length-prefixed frame receiver.
// Drives framed byte streams under several register settings with random
// gaps and back-pressure; depends on lpfr_pkg and lpfr_frame_checker.
module length_prefixed_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpfr_pkg::*;

    localparam int unsigned LEN_BITS       = 16;
    localparam int          CYCLE_LIMIT    = 1_000_000;
    localparam int          BYTES_PER_SET  = 168;
    localparam int          NUM_SETTINGS   = 8;
    localparam int          NUM_DIRECTED   = 23;

    localparam logic [BYTE_W-1:0] DIRECTED_BYTES [NUM_DIRECTED] = '{
        8'h00, 8'hFF,
        8'hA5, 8'h02, 8'h00, 8'hA5, 8'hF0, 8'h55, 8'h5A,
        8'hA5, 8'h00, 8'h00, 8'h01, 8'h5A,
        8'hA5, 8'h01, 8'h00, 8'h33, 8'h00, 8'h00,
        8'hA5, 8'hFC, 8'h00
    };

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_wr_en   = 1'b0;
    logic [INDEX_W-1:0]   i_cfg_index   = '0;
    logic [MAXLEN_W-1:0]  i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic [BYTE_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tready = 1'b0;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [ROLE_W-1:0]    m_axis_tuser;
    logic                 m_axis_tlast;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int stall_left  = 0;
    int quiet_left  = 0;
    int ready_roll;
    int frame_bytes_sent;

    logic [BYTE_W-1:0]   start_val;
    logic [BYTE_W-1:0]   footer_val;
    logic [MAXLEN_W-1:0] max_len_val;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    length_prefixed_frame_receiver #(
        .LENGTH_BITS (LEN_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lpfr_frame_checker #(
        .LENGTH_BITS (LEN_BITS)
    ) frame_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Back-pressure: short and long stalls, with stretches of none
    always @(negedge i_clk) begin
        if (quiet_left > 0) begin
            quiet_left = quiet_left - 1;
        end else if (stall_left == 0) begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 3) quiet_left = $urandom_range(30, 200);
            else if (ready_roll < 20) stall_left = $urandom_range(1, 3);
            else if (ready_roll < 23) stall_left = $urandom_range(10, 40);
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b, input bit gapless);
        int unsigned roll;
        int unsigned gap;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = 0;
        if (!gapless) begin
            roll = $urandom_range(0, 99);
            if (roll >= 97) gap = $urandom_range(15, 50);
            else if (roll >= 85) gap = $urandom_range(2, 6);
            else if (roll >= 60) gap = 1;
        end
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [MAXLEN_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic settle_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [BYTE_W-1:0] start_b,
                                 input logic [BYTE_W-1:0] footer_b,
                                 input logic [MAXLEN_W-1:0] max_len);
        settle_idle();
        write_reg(REG_START_BYTE, MAXLEN_W'(start_b));
        write_reg(REG_FOOTER_BYTE, MAXLEN_W'(footer_b));
        write_reg(REG_MAX_LEN, max_len);
        start_val   = start_b;
        footer_val  = footer_b;
        max_len_val = max_len;
    endtask

    task automatic send_noise();
        int unsigned        count;
        logic [BYTE_W-1:0]  b;
        count = $urandom_range(1, 4);
        repeat (count) begin
            b = BYTE_W'($urandom_range(0, 255));
            if (b == start_val) b[0] = ~b[0];
            push_byte(b, 1'b0);
        end
    endtask

    task automatic send_frame(input bit gapless);
        int unsigned        pick;
        int                 near_len;
        logic [FIELD_W-1:0] plen;
        logic [BYTE_W-1:0]  fold;
        logic [BYTE_W-1:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            plen = FIELD_W'($urandom_range(0, 65535));
            if (int'(plen) + int'(OVERHEAD) <= int'(max_len_val)) plen = plen & 16'h000F;
        end else if (pick < 30 && max_len_val >= 5 && max_len_val <= 64) begin
            near_len = int'(max_len_val) - int'(OVERHEAD) + int'($urandom_range(0, 2)) - 1;
            plen = FIELD_W'((near_len < 0) ? 0 : near_len);
        end else if (pick < 40) begin
            plen = FIELD_W'($urandom_range(13, 40));
        end else begin
            plen = FIELD_W'($urandom_range(0, 12));
        end
        push_byte(start_val, gapless);
        push_byte(plen[7:0], gapless);
        push_byte(plen[15:8], gapless);
        frame_bytes_sent += 3;
        if (int'(plen) + int'(OVERHEAD) <= int'(max_len_val)) begin
            fold = '0;
            repeat (plen) begin
                b    = BYTE_W'($urandom_range(0, 255));
                fold = fold ^ b;
                push_byte(b, gapless);
            end
            // corrupt the check and footer now and then
            if ($urandom_range(0, 9) >= 7) fold = BYTE_W'($urandom_range(0, 255));
            push_byte(fold, gapless);
            b = ($urandom_range(0, 9) < 7) ? footer_val : BYTE_W'($urandom_range(0, 255));
            push_byte(b, gapless);
            frame_bytes_sent += int'(plen) + 2;
        end
    endtask

    initial begin
        logic [BYTE_W-1:0]   set_start  [NUM_SETTINGS];
        logic [BYTE_W-1:0]   set_footer [NUM_SETTINGS];
        logic [MAXLEN_W-1:0] set_max    [NUM_SETTINGS];
        set_start  = '{8'h7E, 8'h00, 8'hFF, BYTE_W'($urandom), BYTE_W'($urandom),
                       BYTE_W'($urandom), BYTE_W'($urandom), 8'h00};
        set_footer = '{8'h7E, 8'hFF, 8'h00, BYTE_W'($urandom), BYTE_W'($urandom),
                       BYTE_W'($urandom), BYTE_W'($urandom), 8'h00};
        set_max    = '{17'd64, 17'd5, 17'd0, 17'd65540, 17'h1FFFF,
                       MAXLEN_W'($urandom_range(6, 40)), 17'd256, 17'd4};

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        apply_setting(8'hA5, 8'h5A, 17'd256);
        foreach (DIRECTED_BYTES[k]) push_byte(DIRECTED_BYTES[k], 1'b0);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            apply_setting(set_start[s], set_footer[s], set_max[s]);
            frame_bytes_sent = 0;
            while (frame_bytes_sent < BYTES_PER_SET) begin
                if ($urandom_range(0, 3) == 0) send_noise();
                send_frame($urandom_range(0, 4) == 0);
            end
        end

        settle_idle();
        repeat (4) @(negedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
